@@ src/pixel_format_converter_serializer_assert.svh @@
// ----------------------------------------------------------------------------
// Pixel format converter assertion macros
// Implication checks on the local clk and rst_n, removed for synthesis.
// ----------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_CONVERTER_SERIALIZER_ASSERT_SVH
`define PIXEL_FORMAT_CONVERTER_SERIALIZER_ASSERT_SVH

`ifndef SYNTHESIS
`define PFCS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfcs: same-cycle check failed");
`define PFCS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfcs: next-cycle check failed");
`else
`define PFCS_ASSERT_IMP(lbl, ante, cons)
`define PFCS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ src/pfcs_pkg.sv @@
// ----------------------------------------------------------------------------
// Pixel format converter package
// Shared constants, types and color widening functions.
// ----------------------------------------------------------------------------
package pfcs_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QCNT_W-1:0] QUEUE_FULL = QCNT_W'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        MODE_IDX16     = 3'd0,
        MODE_RGB332_16 = 3'd1,
        MODE_RGB565    = 3'd2,
        MODE_IDX24     = 3'd3,
        MODE_RGB332_24 = 3'd4,
        MODE_RGB565_24 = 3'd5,
        MODE_DIRECT24  = 3'd6
    } mode_t;

    typedef enum logic {
        OP_PIXEL   = 1'b0,
        OP_PALETTE = 1'b1
    } op_t;

    typedef struct packed {
        logic [23:0] color;
        logic        wide;
    } entry_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } qstat_t;

    function automatic logic [15:0] gray_ramp(input logic [7:0] i);
        return {i[7:3], i[7:2], i[7:3]};
    endfunction

    function automatic logic [15:0] widen_332_565(input logic [7:0] v);
        return {v[7:5], {2{v[5]}}, v[4:2], {3{v[2]}}, v[1:0], {3{v[0]}}};
    endfunction

    function automatic logic [23:0] widen_332_888(input logic [7:0] v);
        return {v[7:5], {5{v[5]}}, v[4:2], {5{v[2]}}, v[1:0], {6{v[0]}}};
    endfunction

    function automatic logic [23:0] widen_565_888(input logic [15:0] v);
        return {v[15:11], 1'b0, {2{v[11]}}, v[10:5], {2{v[5]}}, v[4:0], {3{v[0]}}};
    endfunction

    function automatic logic [15:0] palette_entry(
        input logic       gray,
        input logic [7:0] r,
        input logic [7:0] g,
        input logic [7:0] b
    );
        logic [6:0] sum;
        logic [4:0] y;
        sum = 7'(r[7:3]) + 7'(g[7:2]) + 7'(b[7:3]);
        y   = sum[6:2];
        if (gray)
            return {y, y, 1'b0, y};
        else
            return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

@@ src/pfcs_front.sv @@
// ----------------------------------------------------------------------------
// Pixel format converter front end
// Accepts items, owns the palette, converts pixels and pushes them queued.
// ----------------------------------------------------------------------------
module pfcs_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pix_valid,
    output logic                      pix_ready,
    input  logic                      operation,
    input  logic [23:0]               pixel_value,
    input  logic [7:0]                palette_index,
    input  logic [7:0]                red_in,
    input  logic [7:0]                green_in,
    input  logic [7:0]                blue_in,
    input  pfcs_pkg::mode_t           pixel_mode,
    input  logic                      gray_palette,
    input  pfcs_pkg::qstat_t          qstat,
    output logic                      push,
    output pfcs_pkg::entry_t          push_entry
);

    logic [15:0]                      palette_reg [pfcs_pkg::PALETTE_DEPTH];
    logic [pfcs_pkg::PALETTE_DEPTH-1:0] pal_valid_reg;
    logic                             s1_valid_reg;
    logic                             s1_valid_next;
    logic [23:0]                      s1_pix_reg;
    logic                             s1_inrange_reg;
    logic [15:0]                      rd_data_reg;
    logic                             rd_vld_reg;

    logic                             accept;
    logic                             wr_en;
    logic                             rd_inrange;
    logic [pfcs_pkg::PAL_AW-1:0]      widx;
    logic [pfcs_pkg::PAL_AW-1:0]      ridx;
    logic [15:0]                      pal16;
    logic [15:0]                      wr_data;

    assign pix_ready  = ({1'b0, qstat.count} + (pfcs_pkg::QCNT_W + 1)'(s1_valid_reg))
                        < (pfcs_pkg::QCNT_W + 1)'(pfcs_pkg::QUEUE_DEPTH);
    assign accept     = pix_valid && pix_ready;
    assign widx       = palette_index[pfcs_pkg::PAL_AW-1:0];
    assign ridx       = pixel_value[pfcs_pkg::PAL_AW-1:0];
    assign wr_en      = accept && (pfcs_pkg::op_t'(operation) == pfcs_pkg::OP_PALETTE)
                        && ({1'b0, palette_index} < 9'(pfcs_pkg::PALETTE_DEPTH));
    assign rd_inrange = {1'b0, pixel_value[7:0]} < 9'(pfcs_pkg::PALETTE_DEPTH);
    assign wr_data    = pfcs_pkg::palette_entry(gray_palette, red_in, green_in, blue_in);
    assign s1_valid_next = accept && (pfcs_pkg::op_t'(operation) == pfcs_pkg::OP_PIXEL);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            palette_reg[widx] <= wr_data;
        rd_data_reg    <= palette_reg[ridx];
        rd_vld_reg     <= pal_valid_reg[ridx];
        s1_pix_reg     <= pixel_value;
        s1_inrange_reg <= rd_inrange;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
                pal_valid_reg[widx] <= 1'b1;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_comb
    begin
        if (!s1_inrange_reg)
            pal16 = 16'h0000;
        else if (rd_vld_reg)
            pal16 = rd_data_reg;
        else
            pal16 = pfcs_pkg::gray_ramp(s1_pix_reg[7:0]);
    end

    always_comb
    begin
        push            = s1_valid_reg;
        push_entry.wide = 1'b1;
        unique case (pixel_mode)
            pfcs_pkg::MODE_IDX16:
            begin
                push_entry.color = {pal16, 8'h00};
                push_entry.wide  = 1'b0;
            end
            pfcs_pkg::MODE_RGB332_16:
            begin
                push_entry.color = {pfcs_pkg::widen_332_565(s1_pix_reg[7:0]), 8'h00};
                push_entry.wide  = 1'b0;
            end
            pfcs_pkg::MODE_RGB565:
            begin
                push_entry.color = {s1_pix_reg[15:0], 8'h00};
                push_entry.wide  = 1'b0;
            end
            pfcs_pkg::MODE_IDX24:
                push_entry.color = pfcs_pkg::widen_565_888(pal16);
            pfcs_pkg::MODE_RGB332_24:
                push_entry.color = pfcs_pkg::widen_332_888(s1_pix_reg[7:0]);
            pfcs_pkg::MODE_RGB565_24:
                push_entry.color = pfcs_pkg::widen_565_888(s1_pix_reg[15:0]);
            default:
                push_entry.color = s1_pix_reg;
        endcase
    end

endmodule

@@ src/pfcs_queue.sv @@
// ----------------------------------------------------------------------------
// Pixel format converter queue
// Short queue of converted pixels between the front end and the serializer.
// ----------------------------------------------------------------------------
`include "pixel_format_converter_serializer_assert.svh"

module pfcs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pfcs_pkg::entry_t  push_entry,
    input  logic              pop,
    output pfcs_pkg::entry_t  head,
    output pfcs_pkg::qstat_t  qstat
);

    pfcs_pkg::entry_t                entries_reg [pfcs_pkg::QUEUE_DEPTH];
    logic [pfcs_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [pfcs_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [pfcs_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [pfcs_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [pfcs_pkg::QCNT_W-1:0]     count_reg;
    logic [pfcs_pkg::QCNT_W-1:0]     count_next;

    function automatic logic [pfcs_pkg::QPTR_W-1:0] advance(
        input logic [pfcs_pkg::QPTR_W-1:0] p
    );
        if (p == pfcs_pkg::QPTR_W'(pfcs_pkg::QUEUE_DEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

    assign head        = entries_reg[rd_ptr_reg];
    assign qstat.count = count_reg;
    assign qstat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? advance(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? advance(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `PFCS_ASSERT_IMP(a_no_overflow, push, count_reg != pfcs_pkg::QUEUE_FULL)
    `PFCS_ASSERT_IMP(a_no_underflow, pop, count_reg != '0)
    `PFCS_ASSERT_NXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

@@ src/pfcs_back.sv @@
// ----------------------------------------------------------------------------
// Pixel format converter serializer
// Pops queued pixels and emits their bytes, most significant first.
// ----------------------------------------------------------------------------
`include "pixel_format_converter_serializer_assert.svh"

module pfcs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  pfcs_pkg::entry_t  head,
    input  pfcs_pkg::qstat_t  qstat,
    output logic              pop,
    output logic              byte_valid,
    input  logic              byte_ready,
    output logic [7:0]        out_byte,
    output logic              last_byte
);

    logic [23:0] cur_color_reg;
    logic [23:0] cur_color_next;
    logic [1:0]  cur_left_reg;
    logic [1:0]  cur_left_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_byte_next;
    logic        last_reg;
    logic        last_next;
    logic        out_free;

    assign out_free   = !out_valid_reg || byte_ready;
    assign byte_valid = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign last_byte  = last_reg;

    always_comb
    begin
        pop            = 1'b0;
        cur_color_next = cur_color_reg;
        cur_left_next  = cur_left_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        if (out_free)
        begin
            if (cur_left_reg != 2'd0)
            begin
                out_byte_next  = cur_color_reg[23:16];
                last_next      = (cur_left_reg == 2'd1);
                cur_color_next = {cur_color_reg[15:0], 8'h00};
                cur_left_next  = cur_left_reg - 2'd1;
                out_valid_next = 1'b1;
            end
            else if (!qstat.empty)
            begin
                pop            = 1'b1;
                out_byte_next  = head.color[23:16];
                last_next      = 1'b0;
                cur_color_next = {head.color[15:0], 8'h00};
                cur_left_next  = head.wide ? 2'd2 : 2'd1;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_color_reg <= cur_color_next;
        out_byte_reg  <= out_byte_next;
        last_reg      <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_left_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_left_reg  <= cur_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `PFCS_ASSERT_IMP(a_pending_shown, cur_left_reg != 2'd0, out_valid_reg)
    `PFCS_ASSERT_IMP(a_last_drains, out_valid_reg && last_reg, cur_left_reg == 2'd0)

endmodule

@@ src/pixel_format_converter_serializer.sv @@
// ----------------------------------------------------------------------------
// Pixel format converter and serializer
// A convert item is accepted in one handshake and leaves as two bytes (16-bit
// modes) or three bytes (24-bit modes), one byte per cycle while byte_ready
// is high, so the byte serializer limits the pixel rate. A palette write is
// accepted as one item and produces no byte. The first byte of a pixel passes
// the palette read register, the queue and the output register before it is
// valid. The palette resets to a gray ramp with no clearing pass.
// ----------------------------------------------------------------------------
module pixel_format_converter_serializer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        pix_valid,
    output logic        pix_ready,
    input  logic        operation,
    input  logic [23:0] pixel_value,
    input  logic [7:0]  palette_index,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    output logic        byte_valid,
    input  logic        byte_ready,
    output logic [7:0]  out_byte,
    output logic        last_byte
);

    typedef enum logic {
        REG_PIXEL_MODE   = 1'b0,
        REG_GRAY_PALETTE = 1'b1
    } reg_idx_t;

    pfcs_pkg::mode_t  mode_reg;
    pfcs_pkg::mode_t  mode_next;
    logic             gray_reg;
    logic             gray_next;
    logic             cfg_write;
    reg_idx_t         reg_idx;
    logic             push;
    logic             pop;
    pfcs_pkg::entry_t push_entry;
    pfcs_pkg::entry_t head;
    pfcs_pkg::qstat_t qstat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = reg_idx_t'(paddr[2]);

    always_comb
    begin
        mode_next = mode_reg;
        gray_next = gray_reg;
        prdata    = '0;
        unique case (reg_idx)
            REG_PIXEL_MODE:
            begin
                prdata = {29'd0, mode_reg};
                if (cfg_write)
                    mode_next = pfcs_pkg::mode_t'(pwdata[2:0]);
            end
            REG_GRAY_PALETTE:
            begin
                prdata = {31'd0, gray_reg};
                if (cfg_write)
                    gray_next = pwdata[0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= pfcs_pkg::MODE_RGB565;
            gray_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            gray_reg <= gray_next;
        end
    end

    pfcs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .pix_valid     (pix_valid),
        .pix_ready     (pix_ready),
        .operation     (operation),
        .pixel_value   (pixel_value),
        .palette_index (palette_index),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .pixel_mode    (mode_reg),
        .gray_palette  (gray_reg),
        .qstat         (qstat),
        .push          (push),
        .push_entry    (push_entry)
    );

    pfcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    pfcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .qstat      (qstat),
        .pop        (pop),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .out_byte   (out_byte),
        .last_byte  (last_byte)
    );

endmodule
